// ===== src/rss_pkg.sv =====
// Shared constants and controller/datapath interface types for the restart swap sorter.
package rss_pkg;

   localparam int DEPTH = 64;                 // elements kept per sequence
   localparam int AW    = $clog2(DEPTH);      // store address width
   localparam int CW    = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
   localparam int VW    = 32;                 // Q16.16 sample width

   // Commands from controller to datapath.
   typedef struct packed {
      logic accept;      // take the input transaction into the store
      logic sort_init;   // i <= 1
      logic read_i;      // read store[i]
      logic take_v;      // v <= store[i], j <= i, read store[i-1]
      logic cmp_move;    // store[j] <= store[j-1], j--, read store[j-2]
      logic cmp_place;   // store[j] <= v, i++
      logic emit_init;   // k <= 0
      logic emit_read;   // read store[k], k++, present it next cycle
      logic clear_seq;   // sequence done: count and drop flag to zero
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic i_done;      // outer index reached the element count
      logic gt;          // store[j-1] > v (signed)
      logic j_one;       // j == 1
      logic k_last;      // k addresses the last stored element
   } status_type;

endpackage

// ===== src/rss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rss_datapath.sv =====
// Datapath: element store, sort indexes, compare and result registers.
module rss_datapath import rss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic signed [VW-1:0] req_sample_value,
   output logic                 rsp_strobe,
   output logic signed [VW-1:0] rsp_sorted_value,
   output logic                 rsp_final_result,
   output logic                 rsp_overflow_flag
);

   logic [CW-1:0]        count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [CW-1:0]        k_ff, k_in;
   logic signed [VW-1:0] v_ff, v_in;
   logic                 pending_ff, pending_in;
   logic                 last_ff, last_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [VW-1:0]        wr_data, rd_data;
   logic                 full;
   logic [CW-1:0]        i_m1, j_m1, j_m2;

   assign full = (count_ff == CW'(DEPTH));
   assign i_m1 = i_ff - CW'(1);
   assign j_m1 = j_ff - CW'(1);
   assign j_m2 = j_ff - CW'(2);

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_sample_value;
      if (cmd.accept && !full) begin
         wr_en = 1'b1;
      end else if (cmd.cmp_move) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
         wr_data = rd_data;
      end else if (cmd.cmp_place) begin
         wr_en   = 1'b1;
         wr_addr = j_ff[AW-1:0];
         wr_data = v_ff;
      end

      rd_en   = cmd.read_i | cmd.take_v | cmd.cmp_move | cmd.emit_read;
      rd_addr = k_ff[AW-1:0];
      if (cmd.read_i) begin
         rd_addr = i_ff[AW-1:0];
      end else if (cmd.take_v) begin
         rd_addr = i_m1[AW-1:0];
      end else if (cmd.cmp_move) begin
         rd_addr = j_m2[AW-1:0];
      end
   end

   rss_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next values
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      v_in       = v_ff;
      if (cmd.accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.sort_init) i_in = CW'(1);
      if (cmd.take_v) begin
         v_in = $signed(rd_data);
         j_in = i_ff;
      end
      if (cmd.cmp_move)  j_in = j_m1;
      if (cmd.cmp_place) i_in = i_ff + CW'(1);
      if (cmd.emit_init) k_in = '0;
      if (cmd.emit_read) k_in = k_ff + CW'(1);
      if (cmd.clear_seq) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
      pending_in = cmd.emit_read;
      last_in    = cmd.emit_read && (k_ff == count_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         pending_ff <= 1'b0;
         last_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         pending_ff <= pending_in;
         last_ff    <= last_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      v_ff <= v_in;
   end

   assign status.i_done = (i_ff >= count_ff);
   assign status.gt     = ($signed(rd_data) > v_ff);
   assign status.j_one  = (j_ff == CW'(1));
   assign status.k_last = (k_ff == count_ff - CW'(1));

   assign rsp_strobe        = pending_ff;
   assign rsp_sorted_value  = $signed(rd_data);
   assign rsp_final_result  = last_ff;
   assign rsp_overflow_flag = dropped_ff;

endmodule

// ===== src/rss_controller.sv =====
// Controller: sequences load, insertion sort passes and result emission.
module rss_controller import rss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_final_element,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_NEXT_I,
      S_TAKE_V,
      S_CMP,
      S_PLACE,
      S_EMIT,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_final_element) begin
                  cmd.sort_init = 1'b1;
                  state_in      = S_NEXT_I;
               end
            end
         end
         S_NEXT_I: begin
            if (status.i_done) begin
               cmd.emit_init = 1'b1;
               state_in      = S_EMIT;
            end else begin
               cmd.read_i = 1'b1;
               state_in   = S_TAKE_V;
            end
         end
         S_TAKE_V: begin
            cmd.take_v = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (status.gt) begin
               cmd.cmp_move = 1'b1;
               if (status.j_one) state_in = S_PLACE;
            end else begin
               cmd.cmp_place = 1'b1;
               state_in      = S_NEXT_I;
            end
         end
         S_PLACE: begin
            cmd.cmp_place = 1'b1;
            state_in      = S_NEXT_I;
         end
         S_EMIT: begin
            cmd.emit_read = 1'b1;
            if (status.k_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.clear_seq = 1'b1;
            state_in      = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_LOAD);
      end
   end

   assign busy = busy_ff;

endmodule

// ===== src/restart_swap_sorter_top.sv =====
// Top level of the restart swap sorter: controller plus datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  request  | start & !busy         | req_sample_value, req_final_element
//  response | rsp_strobe            | rsp_sorted_value, rsp_final_result,
//           |                       | rsp_overflow_flag
//
// Loading accepts one transaction per cycle; busy stays low between elements.
// After the transaction carrying the final mark, busy rises and the stored
// elements are insertion sorted in the single-port-write store: each outer
// step reads store[i] into v, shifts each larger element before it up one
// place, one element per cycle, and then writes v into the gap.
// Emission then puts out n results on consecutive cycles, the first in the
// cycle after its read, and busy falls right after the last one.
// Reset is synchronous, active high; it empties the sequence. Results cannot
// be stalled: each one is valid only in its strobe cycle.
module restart_swap_sorter_top import rss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [VW-1:0] req_sample_value,
   input  logic                 req_final_element,
   output logic                 rsp_strobe,
   output logic signed [VW-1:0] rsp_sorted_value,
   output logic                 rsp_final_result,
   output logic                 rsp_overflow_flag
);

   cmd_type    cmd;     // per-cycle datapath commands
   status_type status;  // compare and index flags back to the controller

   rss_controller u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_final_element (req_final_element),
      .status            (status),
      .cmd               (cmd),
      .busy              (busy)
   );

   // Store writes, sort indexes and the response registers live here.
   rss_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample_value  (req_sample_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_sorted_value  (rsp_sorted_value),
      .rsp_final_result  (rsp_final_result),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

endmodule

// ===== src/rss_checker.sv =====
// Port-level checker for the restart swap sorter and its bind.
module rss_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_final_element,
   input logic rsp_strobe,
   input logic rsp_final_result,
   input logic rsp_overflow_flag
);

   // results only appear while a sequence is being processed
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside busy window");

   // a non-final transaction never produces a result
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_final_element) |=> !rsp_strobe)
      else $error("result after non-final transaction");

   // results of a sequence come back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_final_result) |=> rsp_strobe)
      else $error("gap inside result burst");

   // block is free right after the final result
   a_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_result) |=> !busy)
      else $error("busy after final result");

   // overflow flag is the same on every result of a sequence
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_final_result) |=> $stable(rsp_overflow_flag))
      else $error("overflow flag changed within sequence");

endmodule

bind restart_swap_sorter_top rss_checker u_rss_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_final_element (req_final_element),
   .rsp_strobe        (rsp_strobe),
   .rsp_final_result  (rsp_final_result),
   .rsp_overflow_flag (rsp_overflow_flag)
);
